### hw/rtl/glyph_row_pixel_expander_macros.svh
// Assertion helpers for the glyph row expander.
`ifndef GLYPH_ROW_PIXEL_EXPANDER_MACROS_SVH
`define GLYPH_ROW_PIXEL_EXPANDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GRPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("glyph row expander check failed");

// Next-cycle implication, checked out of reset.
`define GRPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("glyph row expander check failed");

`endif

### hw/rtl/grpe_pkg.sv
`timescale 1ns / 1ps

package grpe_pkg;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_RED_SHIFT   = 3'd0,
    REG_GREEN_SHIFT = 3'd1,
    REG_BLUE_SHIFT  = 3'd2,
    REG_BPP         = 3'd3,
    REG_LINE_PITCH  = 3'd4,
    REG_GLYPH_W     = 3'd5,
    REG_GLYPH_H     = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_e;

  localparam int unsigned SlotAw     = 5;   // 32 bytes per glyph slot
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned AlphaPos   = 24;
  localparam logic [5:0]  FullDepth  = 6'd32;

  localparam logic [4:0]  RstRedShift   = 5'd16;
  localparam logic [4:0]  RstGreenShift = 5'd8;
  localparam logic [4:0]  RstBlueShift  = 5'd0;
  localparam logic [5:0]  RstBpp        = 6'd32;
  localparam logic [15:0] RstLinePitch  = 16'd4096;
  localparam logic [4:0]  RstGlyphW     = 5'd8;
  localparam logic [4:0]  RstGlyphH     = 5'd16;

  // Place the color channels; bits pushed past bit 31 fall off.
  function automatic logic [31:0] pack_pixel(input logic [31:0] color,
                                             input logic [4:0]  rs,
                                             input logic [4:0]  gs,
                                             input logic [4:0]  bs,
                                             input logic        alpha_en);
    logic [31:0] w;
    w = (32'(color[7:0]) << rs) | (32'(color[15:8]) << gs) | (32'(color[23:16]) << bs);
    if (alpha_en) begin
      w = w | (32'(color[31:24]) << AlphaPos);
    end
    return w;
  endfunction

endpackage

### hw/rtl/glyph_row_pixel_expander.sv
`timescale 1ns / 1ps
// Channel  | Beat                                               | Handshake
// ---------+----------------------------------------------------+---------------------------
// input    | opcode, char_code, byte_index, font_byte,          | in_valid_i / in_stall_o
//          | glyph_row, pos_x, pos_y, fore_rgba, back_rgba      |
// output   | write_offset, pixel_word, last_of_row              | out_valid_o / out_stall_i
// config   | cfg_idx_i, cfg_wdata_i                             | cfg_we_i
//
// One pixel per cycle while the output is not stalled: a draw steps the column counter across
// the glyph width, and a load or an empty draw does not step it. The single font store port (one
// write or one read a cycle) and the column counter set that rate. The first pixel of a draw
// passes the stage 1 item registers, the stage 2 read data and the output register in turn.
// Reset restores the register defaults; the font store is not cleared.
// A stalled output freezes all stages; nothing is dropped or repeated.

module glyph_row_pixel_expander
  import grpe_pkg::*;
#(
  parameter int unsigned CHAR_COUNT       = 256,
  parameter int unsigned MAX_GLYPH_WIDTH  = 16,
  parameter int unsigned MAX_GLYPH_HEIGHT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [7:0]          char_code_i,
  input  logic [4:0]          byte_index_i,
  input  logic [7:0]          font_byte_i,
  input  logic [3:0]          glyph_row_i,
  input  logic [11:0]         pos_x_i,
  input  logic [11:0]         pos_y_i,
  input  logic [31:0]         fore_rgba_i,
  input  logic [31:0]         back_rgba_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         write_offset_o,
  output logic [31:0]         pixel_word_o,
  output logic                last_of_row_o
);

  localparam int unsigned ChW      = $clog2(CHAR_COUNT);
  localparam int unsigned MemDepth = CHAR_COUNT * (2 ** SlotAw);
  localparam int unsigned AddrW    = ChW + SlotAw;
  localparam int unsigned ColW     = $clog2(MAX_GLYPH_WIDTH);

  // ---------------- configuration ----------------
  logic [4:0]  r_pos_q, g_pos_q, b_pos_q;
  logic [5:0]  bpp_q;
  logic [15:0] line_pitch_q;
  logic [4:0]  glyph_w_q, glyph_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_pos_q       <= RstRedShift;
      g_pos_q       <= RstGreenShift;
      b_pos_q       <= RstBlueShift;
      bpp_q         <= RstBpp;
      line_pitch_q  <= RstLinePitch;
      glyph_w_q     <= RstGlyphW;
      glyph_h_q     <= RstGlyphH;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RED_SHIFT:   r_pos_q       <= cfg_wdata_i[4:0];
        REG_GREEN_SHIFT: g_pos_q       <= cfg_wdata_i[4:0];
        REG_BLUE_SHIFT:  b_pos_q       <= cfg_wdata_i[4:0];
        REG_BPP:         bpp_q         <= cfg_wdata_i[5:0];
        REG_LINE_PITCH:  line_pitch_q  <= cfg_wdata_i;
        REG_GLYPH_W:     glyph_w_q     <= cfg_wdata_i[4:0];
        REG_GLYPH_H:     glyph_h_q     <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] width_eff;
  logic       row_out;
  logic       wide_row;

  always_comb begin
    width_eff = (glyph_w_q > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : glyph_w_q;
    wide_row  = width_eff > 5'd8;
  end

  // ---------------- stage 1: item held, column counter ----------------
  logic            busy_q, busy_d;
  logic [ColW-1:0] col_q, col_d;
  op_e             it_op_q;
  logic [7:0]      it_char_q;
  logic [4:0]      it_bidx_q;
  logic [7:0]      it_byte_q;
  logic [3:0]      it_row_q;
  logic [11:0]     it_px_q, it_py_q;
  logic [31:0]     it_fg_q, it_bg_q;

  logic en, col_last, empty, beat, item_done, take, accept;

  // rows at or past the (saturated) glyph height draw nothing
  always_comb begin
    if ({1'b0, glyph_h_q} >= 6'(MAX_GLYPH_HEIGHT)) begin
      row_out = {2'b00, it_row_q} >= 6'(MAX_GLYPH_HEIGHT);
    end else begin
      row_out = {1'b0, it_row_q} >= glyph_h_q;
    end
  end

  logic out_valid_q;

  always_comb begin
    en        = !out_valid_q || !out_stall_i;
    col_last  = (5'(col_q) + 5'd1) == width_eff;
    empty     = (width_eff == 5'd0) || row_out;
    beat      = busy_q && (it_op_q == OP_DRAW) && !empty;
    item_done = busy_q && ((it_op_q == OP_LOAD) || empty || col_last);
    take      = en && (!busy_q || item_done);
    accept    = in_valid_i && take;
    in_stall_o = !take;

    busy_d = busy_q;
    col_d  = col_q;
    if (take) begin
      busy_d = in_valid_i;
      col_d  = '0;
    end else if (en && beat) begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else begin
      busy_q <= busy_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_op_q   <= op_e'(opcode_i);
      it_char_q <= char_code_i;
      it_bidx_q <= byte_index_i;
      it_byte_q <= font_byte_i;
      it_row_q  <= glyph_row_i;
      it_px_q   <= pos_x_i;
      it_py_q   <= pos_y_i;
      it_fg_q   <= fore_rgba_i;
      it_bg_q   <= back_rgba_i;
    end
  end

  // ---------------- font store address ----------------
  logic [8:0]       ch_ext, ch_mod;
  logic [4:0]       row_off, slot_byte;
  logic [AddrW-1:0] mem_addr;

  always_comb begin
    // char_code < 2 * CHAR_COUNT, so one subtract wraps it
    ch_ext  = {1'b0, it_char_q};
    ch_mod  = (ch_ext >= 9'(CHAR_COUNT)) ? ch_ext - 9'(CHAR_COUNT) : ch_ext;
    row_off = wide_row ? {it_row_q, 1'b0} : {1'b0, it_row_q};
    if (it_op_q == OP_LOAD) begin
      slot_byte = it_bidx_q;
    end else begin
      slot_byte = row_off + 5'(col_q >> 3);
    end
    mem_addr = {ch_mod[ChW-1:0], slot_byte};
  end

  logic [7:0] font_mem [MemDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en && busy_q && (it_op_q == OP_LOAD)) begin
      font_mem[mem_addr] <= it_byte_q;
    end
    if (en && beat) begin
      rdata_q <= font_mem[mem_addr];
    end
  end

  // ---------------- stage 2: read data, address products ----------------
  logic        p2_valid_q;
  logic [2:0]  p2_bit_q;
  logic        p2_last_q;
  logic [28:0] p2_ybase_q;
  logic [15:0] p2_xoff_q;
  logic [31:0] p2_fg_q, p2_bg_q;
  logic [12:0] ysum, xsum;

  always_comb begin
    ysum = {1'b0, it_py_q} + 13'(it_row_q);
    xsum = {1'b0, it_px_q} + 13'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && beat) begin
      p2_bit_q   <= col_q[2:0];
      p2_last_q  <= col_last;
      p2_ybase_q <= 29'(ysum) * 29'(line_pitch_q);
      p2_xoff_q  <= 16'(xsum) * 16'(bpp_q[5:3]);
      p2_fg_q    <= it_fg_q;
      p2_bg_q    <= it_bg_q;
    end
  end

  // ---------------- stage 3: output register ----------------
  logic [31:0] write_offset_q, pixel_word_q;
  logic        last_q;
  logic        pix_set;

  // MSB of a font byte is the leftmost pixel
  assign pix_set = rdata_q[3'd7 - p2_bit_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p2_valid_q) begin
      write_offset_q <= 32'(p2_ybase_q) + 32'(p2_xoff_q);
      pixel_word_q   <= pack_pixel(pix_set ? p2_fg_q : p2_bg_q, r_pos_q,
                                   g_pos_q, b_pos_q, bpp_q == FullDepth);
      last_q         <= p2_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_offset_o = write_offset_q;
  assign pixel_word_o   = pixel_word_q;
  assign last_of_row_o  = last_q;

  // ---------------- checks ----------------
`include "glyph_row_pixel_expander_macros.svh"

  `GRPE_ASSERT_NXT(a_p2_holds, clk_i, rst_ni, p2_valid_q && !en, p2_valid_q)
  `GRPE_ASSERT_NXT(a_item_holds, clk_i, rst_ni, busy_q && !en, busy_q && $stable(col_q))
  `GRPE_ASSERT_IMP(a_col_in_row, clk_i, rst_ni, beat, 5'(col_q) < width_eff)

endmodule
